// ----- rtl/core/matrix_multiply_assert.svh -----
// Assertion macros used by the matrix multiply port checker.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Check a property at each clock edge, skipped while reset is high.
`define MM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property at each clock edge, including the reset cycles.
`define MM_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/core/mm_pkg.sv -----
// Shared types and constants of the matrix multiply block.
package mm_pkg;

   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int CFG_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int KIND_W    = 2;
   localparam int POS_W     = 2;
   localparam int MAX_IDX_W = 4;

   localparam logic [KIND_W-1:0] KIND_LOAD_LEFT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_RIGHT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPUTE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

   localparam logic [CFG_W-1:0] DIM_RESET = 3'd4;

   localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

   // One product element on its way down the chain.
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [MAX_IDX_W-1:0] row;
      logic [MAX_IDX_W-1:0] col;
   } token_type;

   // Element write broadcast to the cells.
   typedef struct packed {
      logic                 we_left;
      logic                 we_right;
      logic [MAX_IDX_W-1:0] sel;
      logic [MAX_IDX_W-1:0] addr;
      logic [ELEM_W-1:0]    data;
   } load_type;

endpackage

// ----- rtl/core/mm_ifs.sv -----
// Request and response channel interfaces of the matrix multiply block.
interface mm_req_if import mm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [POS_W-1:0]  row_index;
   logic [POS_W-1:0]  col_index;
   logic [ELEM_W-1:0] element_value;

   modport source (output valid, kind, row_index, col_index, element_value, input ready);
   modport sink (input valid, kind, row_index, col_index, element_value, output ready);
endinterface

interface mm_rsp_if import mm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  out_row;
   logic [POS_W-1:0]  out_col;
   logic [ELEM_W-1:0] product_value;
   logic              saturated;
   logic              last;

   modport source (output valid, out_row, out_col, product_value, saturated, last,
                   input ready);
   modport sink (input valid, out_row, out_col, product_value, saturated, last,
                 output ready);
endinterface

// ----- rtl/core/mm_cell.sv -----
// One cell of the multiply chain: holds left column k and right row k, adds one term.
module mm_cell import mm_pkg::*; #(
   parameter int MAX_DIM  = 4,
   parameter int CELL_POS = 0
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     enable,
   input  logic [CFG_W-1:0]                         inner_size,
   input  load_type                                 load,
   input  token_type                                tok_in,
   input  logic signed [PROD_W+$clog2(MAX_DIM)-1:0] psum_in,
   output token_type                                tok_out,
   output logic signed [PROD_W+$clog2(MAX_DIM)-1:0] psum_out,
   output logic                                     busy
);

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ACC_W = PROD_W + $clog2(MAX_DIM);

   logic [ELEM_W-1:0] left_col_ff  [MAX_DIM];
   logic [ELEM_W-1:0] right_row_ff [MAX_DIM];

   token_type                 tok1_ff, tok2_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   psum1_ff, sum_ff, sum_in;
   logic signed [ELEM_W-1:0]  left_sel, right_sel;
   logic                      active;

   // Element stores; no reset, an entry is defined once written.
   always_ff @(posedge clock) begin
      if (load.we_left && load.sel == MAX_IDX_W'(CELL_POS)) begin
         left_col_ff[load.addr[IDX_W-1:0]] <= load.data;
      end
      if (load.we_right && load.sel == MAX_IDX_W'(CELL_POS)) begin
         right_row_ff[load.addr[IDX_W-1:0]] <= load.data;
      end
   end

   assign left_sel  = $signed(left_col_ff[tok_in.row[IDX_W-1:0]]);
   assign right_sel = $signed(right_row_ff[tok_in.col[IDX_W-1:0]]);
   assign prod_in   = PROD_W'(left_sel) * PROD_W'(right_sel);

   // Terms beyond the inner size pass the partial sum through.
   assign active = int'(inner_size) > CELL_POS;
   assign sum_in = active ? (psum1_ff + ACC_W'(prod_ff)) : psum1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff.valid <= 1'b0;
         tok2_ff.valid <= 1'b0;
      end else if (enable) begin
         tok1_ff  <= tok_in;
         tok2_ff  <= tok1_ff;
         prod_ff  <= prod_in;
         psum1_ff <= psum_in;
         sum_ff   <= sum_in;
      end
   end

   assign tok_out  = tok2_ff;
   assign psum_out = sum_ff;
   assign busy     = tok1_ff.valid | tok2_ff.valid;

endmodule

// ----- rtl/core/matrix_multiply.sv -----
// Matrix multiply top level: element loads, sequencer, cell chain and output stage.
// Load items (left or right element) are taken one per cycle while ready is high
// and give no result. A compute item emits left_rows * right_cols results, row by
// row; the sequencer injects one product element per cycle, while the output does
// not stall, into a chain of MAX_DIM cells, cell k holding left column k and right
// row k and adding one term (multiply stage, then add stage). Each result passes
// both stages of every cell and then the output register. req ready drops from a
// compute transfer until the last element has left the chain, and output stalls
// hold it low longer. Results are the wide sum shifted right by FRAC_BITS (floor)
// and saturated to 32 bits. Size registers take 0 as 1 and clip values above
// MAX_DIM; loads at a row or column at or beyond MAX_DIM are dropped; kind 3 is
// dropped.
module matrix_multiply import mm_pkg::*; #(
   parameter int MAX_DIM   = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   mm_req_if.sink               req_chan,
   mm_rsp_if.source             rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ACC_W = PROD_W + $clog2(MAX_DIM);
   localparam int CMP_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = CFG_W'(MAX_DIM);
      end
      return r;
   endfunction

   logic [CFG_W-1:0] left_rows_ff, inner_size_ff, right_cols_ff;

   logic             issuing_ff, issuing_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic             row_last, col_last;
   logic             req_xfer, in_range, chain_en, chain_busy;
   load_type         load;

   token_type               tok_chain [MAX_DIM+1];
   logic signed [ACC_W-1:0] sum_chain [MAX_DIM+1];
   logic [MAX_DIM-1:0]      busy_vec;

   logic signed [ACC_W-1:0] shifted;
   logic                    fits;

   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic [ELEM_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_sat_ff, rsp_last_ff;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= clamp_dim(DIM_RESET);
         inner_size_ff <= clamp_dim(DIM_RESET);
         right_cols_ff <= clamp_dim(DIM_RESET);
      end else if (csr_we) begin
         case (csr_index)
            REG_LEFT_ROWS:  left_rows_ff  <= clamp_dim(csr_wdata);
            REG_INNER_SIZE: inner_size_ff <= clamp_dim(csr_wdata);
            REG_RIGHT_COLS: right_cols_ff <= clamp_dim(csr_wdata);
            default: ;
         endcase
      end
   end

   assign chain_busy     = |busy_vec;
   assign req_chan.ready = !issuing_ff && !chain_busy;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign chain_en       = !rsp_valid_ff || rsp_chan.ready;

   // Broadcast element writes to the cells
   assign in_range = (int'(req_chan.row_index) < MAX_DIM) &&
                     (int'(req_chan.col_index) < MAX_DIM);

   always_comb begin
      load.we_left  = req_xfer && in_range && (req_chan.kind == KIND_LOAD_LEFT);
      load.we_right = req_xfer && in_range && (req_chan.kind == KIND_LOAD_RIGHT);
      load.data     = req_chan.element_value;
      if (req_chan.kind == KIND_LOAD_LEFT) begin
         load.sel  = MAX_IDX_W'(req_chan.col_index);
         load.addr = MAX_IDX_W'(req_chan.row_index);
      end else begin
         load.sel  = MAX_IDX_W'(req_chan.row_index);
         load.addr = MAX_IDX_W'(req_chan.col_index);
      end
   end

   // Sequencer over product elements
   assign row_last = (CMP_W'(row_ff) + CMP_W'(1)) == CMP_W'(left_rows_ff);
   assign col_last = (CMP_W'(col_ff) + CMP_W'(1)) == CMP_W'(right_cols_ff);

   always_comb begin
      issuing_in = issuing_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      if (req_xfer && req_chan.kind == KIND_COMPUTE) begin
         issuing_in = 1'b1;
         row_in     = '0;
         col_in     = '0;
      end else if (issuing_ff && chain_en) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               issuing_in = 1'b0;
            end else begin
               row_in = row_ff + IDX_W'(1);
            end
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         row_ff     <= '0;
         col_ff     <= '0;
      end else begin
         issuing_ff <= issuing_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
      end
   end

   always_comb begin
      tok_chain[0].valid = issuing_ff;
      tok_chain[0].last  = row_last && col_last;
      tok_chain[0].row   = MAX_IDX_W'(row_ff);
      tok_chain[0].col   = MAX_IDX_W'(col_ff);
   end
   assign sum_chain[0] = '0;

   for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
      mm_cell #(
         .MAX_DIM  (MAX_DIM),
         .CELL_POS (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (chain_en),
         .inner_size (inner_size_ff),
         .load       (load),
         .tok_in     (tok_chain[k]),
         .psum_in    (sum_chain[k]),
         .tok_out    (tok_chain[k+1]),
         .psum_out   (sum_chain[k+1]),
         .busy       (busy_vec[k])
      );
   end

   // Scale back to Q16.16 and clip
   assign shifted = sum_chain[MAX_DIM] >>> FRAC_BITS;
   assign fits    = (&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]);
   assign rsp_value_in = fits ? shifted[ELEM_W-1:0] :
                         (shifted[ACC_W-1] ? Q_MIN : Q_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_en) begin
         rsp_valid_ff <= tok_chain[MAX_DIM].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_en) begin
         rsp_row_ff   <= POS_W'(tok_chain[MAX_DIM].row);
         rsp_col_ff   <= POS_W'(tok_chain[MAX_DIM].col);
         rsp_value_ff <= rsp_value_in;
         rsp_sat_ff   <= !fits;
         rsp_last_ff  <= tok_chain[MAX_DIM].last;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_row       = rsp_row_ff;
   assign rsp_chan.out_col       = rsp_col_ff;
   assign rsp_chan.product_value = rsp_value_ff;
   assign rsp_chan.saturated     = rsp_sat_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule

// ----- rtl/core/mm_checker.sv -----
// Port-level checks of the matrix multiply block and their bind to the top level.
`include "matrix_multiply_assert.svh"

module mm_checker import mm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [KIND_W-1:0] req_kind,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [POS_W-1:0]  rsp_out_row,
   input logic [POS_W-1:0]  rsp_out_col,
   input logic [ELEM_W-1:0] rsp_product_value,
   input logic              rsp_saturated,
   input logic              rsp_last
);

   logic                          compute_xfer;
   logic                          rsp_stall;
   logic                          at_limit;
   logic [2*POS_W+ELEM_W+1:0]     rsp_payload;

   assign compute_xfer = req_valid && req_ready && (req_kind == KIND_COMPUTE);
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign at_limit     = (rsp_product_value == Q_MAX) || (rsp_product_value == Q_MIN);
   assign rsp_payload  = {rsp_out_row, rsp_out_col, rsp_product_value, rsp_saturated,
                          rsp_last};

   `MM_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_valid, "result valid after reset")
   `MM_ASSERT(a_busy_after_compute, compute_xfer |=> !req_ready, "input open after compute")
   `MM_ASSERT(a_sat_value, rsp_valid && rsp_saturated |-> at_limit, "saturated off limit")
   `MM_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled result moved")

endmodule

bind matrix_multiply mm_checker u_mm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_kind          (req_chan.kind),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_out_row       (rsp_chan.out_row),
   .rsp_out_col       (rsp_chan.out_col),
   .rsp_product_value (rsp_chan.product_value),
   .rsp_saturated     (rsp_chan.saturated),
   .rsp_last          (rsp_chan.last)
);

// ----- dv/matrix_multiply_checker.sv -----
// Result checker for the matrix multiply block: tracks stores and sizes, predicts each product.
module matrix_multiply_checker import mm_pkg::*; #(
   parameter int MAX_DIM   = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   mm_req_if                    req_mon,
   mm_rsp_if                    rsp_mon,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   pending,
   output int                   failures
);

   typedef struct packed {
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [ELEM_W-1:0] value;
      logic              sat;
      logic              last;
   } product_type;

   logic [ELEM_W-1:0] left_elems  [MAX_DIM*MAX_DIM];
   logic [ELEM_W-1:0] right_elems [MAX_DIM*MAX_DIM];
   int                rows_used;
   int                inner_used;
   int                cols_used;
   int                mismatch_count = 0;
   product_type       expected_products [$];

   function automatic int clip_dim(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > MAX_DIM) begin
         return MAX_DIM;
      end
      return int'(v);
   endfunction

   // Exact wide sum, floor shift, then clip to the Q16.16 range.
   function automatic product_type dot_element(input int r, input int c);
      logic signed [127:0] acc;
      logic signed [127:0] scaled;
      product_type         e;
      acc = '0;
      for (int k = 0; k < inner_used; k++) begin
         acc = acc + $signed(left_elems[r*MAX_DIM+k]) * $signed(right_elems[k*MAX_DIM+c]);
      end
      scaled = acc >>> FRAC_BITS;
      e.row  = r[POS_W-1:0];
      e.col  = c[POS_W-1:0];
      if (scaled[127:ELEM_W-1] == '0 || scaled[127:ELEM_W-1] == '1) begin
         e.value = scaled[ELEM_W-1:0];
         e.sat   = 1'b0;
      end else begin
         e.value = scaled[127] ? Q_MIN : Q_MAX;
         e.sat   = 1'b1;
      end
      e.last = (r == rows_used - 1) && (c == cols_used - 1);
      return e;
   endfunction

   always @(posedge clock) begin : monitor
      product_type got;
      product_type want;
      int          row;
      int          col;
      if (reset) begin
         rows_used  = clip_dim(DIM_RESET);
         inner_used = clip_dim(DIM_RESET);
         cols_used  = clip_dim(DIM_RESET);
         expected_products.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_LEFT_ROWS:  rows_used  = clip_dim(csr_wdata);
               REG_INNER_SIZE: inner_used = clip_dim(csr_wdata);
               REG_RIGHT_COLS: cols_used  = clip_dim(csr_wdata);
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            row = int'(req_mon.row_index);
            col = int'(req_mon.col_index);
            case (req_mon.kind)
               KIND_LOAD_LEFT: begin
                  if (row < MAX_DIM && col < MAX_DIM) begin
                     left_elems[row*MAX_DIM+col] = req_mon.element_value;
                  end
               end
               KIND_LOAD_RIGHT: begin
                  if (row < MAX_DIM && col < MAX_DIM) begin
                     right_elems[row*MAX_DIM+col] = req_mon.element_value;
                  end
               end
               KIND_COMPUTE: begin
                  for (int r = 0; r < rows_used; r++) begin
                     for (int c = 0; c < cols_used; c++) begin
                        expected_products = {expected_products, dot_element(r, c)};
                     end
                  end
               end
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.row   = rsp_mon.out_row;
            got.col   = rsp_mon.out_col;
            got.value = rsp_mon.product_value;
            got.sat   = rsp_mon.saturated;
            got.last  = rsp_mon.last;
            if (expected_products.size() == 0) begin
               $error("unexpected product transfer row %0d col %0d value %h",
                      got.row, got.col, got.value);
               mismatch_count++;
            end else begin
               want = expected_products.pop_front();
               if (got.row !== want.row) begin
                  $error("out_row expected %0d got %0d", want.row, got.row);
                  mismatch_count++;
               end
               if (got.col !== want.col) begin
                  $error("out_col expected %0d got %0d", want.col, got.col);
                  mismatch_count++;
               end
               if (got.value !== want.value) begin
                  $error("product_value expected %h got %h", want.value, got.value);
                  mismatch_count++;
               end
               if (got.sat !== want.sat) begin
                  $error("saturated expected %b got %b", want.sat, got.sat);
                  mismatch_count++;
               end
               if (got.last !== want.last) begin
                  $error("last expected %b got %b", want.last, got.last);
                  mismatch_count++;
               end
            end
         end
      end
      pending  <= expected_products.size();
      failures <= mismatch_count;
   end

endmodule

// ----- dv/testbench.sv -----
// Top of the matrix multiply testbench: clock, reset, stimulus, result drain and verdict.
module testbench;
   import mm_pkg::*;

   localparam int MAX_DIM          = 4;
   localparam int FRAC_BITS        = 16;
   localparam int SETTLE_CYCLES    = 3 * MAX_DIM + 12;
   localparam int HOLD_OFF_CYCLES  = 160;
   localparam int CYCLE_LIMIT      = 150000;
   localparam int NUM_PHASES       = 7;
   localparam int PHASE_ITEMS      = 22;
   localparam int IDLE_PERCENT     = 31;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   logic                 no_idle;
   logic                 hold_off_asked;
   logic                 hold_off_done;
   int                   pending;
   int                   failures;
   int                   cycle_count = 0;

   mm_req_if req_chan ();
   mm_rsp_if rsp_chan ();

   matrix_multiply #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   matrix_multiply_checker #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) checker_inst (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_chan),
      .rsp_mon   (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .failures  (failures)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL matrix_multiply");
         $finish;
      end
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin : result_drain
      rsp_chan.ready = 1'b0;
      hold_off_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_asked && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= !reset && (no_idle || $urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   function automatic logic [ELEM_W-1:0] pick_element();
      case ($urandom_range(3))
         0: return $urandom();
         1: begin
            case ($urandom_range(2))
               0: return Q_MAX;
               1: return Q_MIN;
               default: return '0;
            endcase
         end
         // Within +-16.0, so sums stay in range and truncation shows.
         default: return ELEM_W'($urandom_range(32'h001F_FFFF)) - 32'h0010_0000;
      endcase
   endfunction

   // Hold valid across back-to-back transfers; drop it only for a gap.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col, input logic [ELEM_W-1:0] value);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.kind          <= kind;
      req_chan.row_index     <= row;
      req_chan.col_index     <= col;
      req_chan.element_value <= value;
      do
         @(posedge clock);
      while (!req_chan.ready);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                            input logic [CFG_W-1:0] cols);
      csr_we    <= 1'b1;
      csr_index <= REG_LEFT_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= REG_INNER_SIZE;
      csr_wdata <= inner;
      @(posedge clock);
      csr_index <= REG_RIGHT_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic fill_stores();
      for (int r = 0; r < MAX_DIM; r++) begin
         for (int c = 0; c < MAX_DIM; c++) begin
            send_item(KIND_LOAD_LEFT, r[POS_W-1:0], c[POS_W-1:0], pick_element());
            send_item(KIND_LOAD_RIGHT, r[POS_W-1:0], c[POS_W-1:0], pick_element());
         end
      end
   endtask

   // Mostly load bursts closed by a compute; the rest single random items.
   task automatic run_phase(input int budget);
      int               sent;
      int               burst;
      logic [KIND_W-1:0] kind;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 75) begin
            burst = $urandom_range(6);
            repeat (burst) begin
               kind = $urandom_range(1) ? KIND_LOAD_RIGHT : KIND_LOAD_LEFT;
               send_item(kind, POS_W'($urandom_range(3)), POS_W'($urandom_range(3)),
                         pick_element());
               sent++;
            end
            send_item(KIND_COMPUTE, POS_W'($urandom_range(3)), POS_W'($urandom_range(3)),
                      $urandom());
            sent++;
         end else begin
            kind = KIND_W'($urandom_range(3));
            send_item(kind, POS_W'($urandom_range(3)), POS_W'($urandom_range(3)),
                      pick_element());
            if (kind != KIND_UNUSED) begin
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = REG_LEFT_ROWS;
      csr_wdata              = '0;
      no_idle                = 1'b0;
      hold_off_asked         = 1'b0;
      req_chan.valid         = 1'b0;
      req_chan.kind          = KIND_LOAD_LEFT;
      req_chan.row_index     = '0;
      req_chan.col_index     = '0;
      req_chan.element_value = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Single dot product over the full inner size; zero rows is taken as one.
      configure(3'd0, 3'd4, 3'd1);
      send_item(KIND_LOAD_LEFT, 2'd0, 2'd0, Q_MAX);
      send_item(KIND_LOAD_LEFT, 2'd0, 2'd1, Q_MIN);
      send_item(KIND_LOAD_LEFT, 2'd0, 2'd2, Q_MAX);
      send_item(KIND_LOAD_LEFT, 2'd0, 2'd3, Q_MIN);
      send_item(KIND_LOAD_RIGHT, 2'd0, 2'd0, Q_MAX);
      send_item(KIND_LOAD_RIGHT, 2'd1, 2'd0, Q_MIN);
      send_item(KIND_LOAD_RIGHT, 2'd2, 2'd0, Q_MAX);
      send_item(KIND_LOAD_RIGHT, 2'd3, 2'd0, Q_MIN);
      // All terms positive: clip high.
      send_item(KIND_COMPUTE, 2'd3, 2'd3, '0);
      // Large terms cancel down to exactly one.
      send_item(KIND_LOAD_RIGHT, 2'd0, 2'd0, Q_MIN);
      send_item(KIND_LOAD_RIGHT, 2'd2, 2'd0, Q_MIN);
      send_item(KIND_COMPUTE, 2'd0, 2'd0, '1);
      // All terms negative: clip low.
      send_item(KIND_LOAD_LEFT, 2'd0, 2'd1, Q_MAX);
      send_item(KIND_LOAD_LEFT, 2'd0, 2'd3, Q_MAX);
      send_item(KIND_COMPUTE, 2'd1, 2'd2, 32'h5555_AAAA);
      // Unused kind: must be dropped.
      send_item(KIND_UNUSED, 2'd3, 2'd3, '1);
      send_item(KIND_COMPUTE, 2'd2, 2'd1, 32'hAAAA_5555);
      wait_idle();

      fill_stores();
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         case (p)
            0: configure(3'd7, 3'd1, 3'd0);
            1: configure(3'd1, 3'd0, 3'd3);
            2: configure(3'd2, 3'd7, 3'd4);
            3: configure(3'd5, 3'd3, 3'd6);
            4: configure(3'd4, 3'd4, 3'd4);
            default: configure(CFG_W'($urandom_range(7)), CFG_W'($urandom_range(7)),
                               CFG_W'($urandom_range(7)));
         endcase
         if (p == 2) begin
            hold_off_asked <= 1'b1;
         end
         no_idle <= (p == 4);
         run_phase(PHASE_ITEMS);
      end
      wait_idle();

      if (failures == 0) begin
         $display("PASS matrix_multiply");
      end else begin
         $display("FAIL matrix_multiply");
      end
      $finish;
   end

endmodule
